### hw/rtl/flpc_pkg.sv
// ----------------------------------------------------------------------------
// flpc_pkg: shared types and codes for the frame LRU page cache
// Item structs, operation and result codes, controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package flpc_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key_high;
    logic [31:0] key_low;
    logic        key_valid;
    logic [63:0] frame_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  page_index;
    logic [31:0] page_generation;
    logic [31:0] evictions_in_frame;
    logic [6:0]  cached_count;
    logic [6:0]  dirty_count;
    logic [6:0]  clean_count;
  } out_item_t;

  localparam logic [2:0] OP_REQUEST   = 3'd0;
  localparam logic [2:0] OP_BEGIN     = 3'd1;
  localparam logic [2:0] OP_RENDERED  = 3'd2;
  localparam logic [2:0] OP_INVAL     = 3'd3;
  localparam logic [2:0] OP_INVAL_ALL = 3'd4;

  localparam logic [2:0] RS_HIT       = 3'd0;
  localparam logic [2:0] RS_FRESH     = 3'd1;
  localparam logic [2:0] RS_EVICT     = 3'd2;
  localparam logic [2:0] RS_INVALID   = 3'd3;
  localparam logic [2:0] RS_NO_PAGE   = 3'd4;
  localparam logic [2:0] RS_FOUND     = 3'd5;
  localparam logic [2:0] RS_NOT_FOUND = 3'd6;
  localparam logic [2:0] RS_DONE      = 3'd7;

  localparam logic [1:0] PS_FREE  = 2'd0;
  localparam logic [1:0] PS_DIRTY = 2'd1;
  localparam logic [1:0] PS_CLEAN = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic pick;
    logic commit;
  } flpc_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } flpc_stat_t;

endpackage

`default_nettype wire

### hw/rtl/flpc_ctrl.sv
// ----------------------------------------------------------------------------
// flpc_ctrl: sequencer of the page cache
// Steps one item through load, an optional tag scan and drain, page pick and commit; owns out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module flpc_ctrl import flpc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire flpc_stat_t stat,
  output flpc_cmd_t       cmd
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN, S_PICK, S_COMMIT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.need_scan) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_PICK;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_PICK;
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> slot_free) else $error("commit into a held result");
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stat.scan_last) |=> state_r == S_DRAIN)
    else $error("scan did not end");
  a_valid_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid) else $error("result lost");
`endif

endmodule

`default_nettype wire

### hw/rtl/flpc_dp.sv
// ----------------------------------------------------------------------------
// flpc_dp: page cache datapath
// Tag and frame memories, page state flops, scan compare, commit and result.
// ----------------------------------------------------------------------------
`default_nettype none

module flpc_dp import flpc_pkg::*; #(
  parameter int PAGES     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire flpc_cmd_t cmd,
  output flpc_stat_t     stat,
  output out_item_t      out_data
);

  localparam int PW = $clog2(PAGES);
  localparam int CW = $clog2(PAGES + 1);
  localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

  logic [KW-1:0] key_hi_mem [PAGES];
  logic [KW-1:0] key_lo_mem [PAGES];
  logic [63:0]   lf_mem     [PAGES];
  logic [31:0]   gen_mem    [PAGES];
  logic [1:0]    pstat_r    [PAGES];
  logic          pin_r      [PAGES];

  logic [2:0]    op_r;
  logic [KW-1:0] kh_r, kl_r;
  logic          kv_r;
  logic [63:0]   fin_r;

  logic [PW-1:0] scan_cnt_r, cmp_idx_r;
  logic          cmp_vld_r;
  logic [KW-1:0] rd_kh_r, rd_kl_r;
  logic [63:0]   rd_lf_r;
  logic [1:0]    rd_st_r;
  logic          rd_pin_r;

  logic          hit_found_r, old_found_r;
  logic [PW-1:0] hit_idx_r, old_idx_r;
  logic [1:0]    hit_st_r, old_st_r;
  logic [63:0]   old_best_r;

  logic [2:0]    code_r, code_nxt;
  logic [PW-1:0] pg_r, pg_nxt;
  logic [1:0]    sel_st_r, sel_st_nxt;
  logic [31:0]   gen_rd_r;

  logic [CW-1:0] fresh_r, cached_r, dirty_r, clean_r;
  logic [CW-1:0] cached_nxt, dirty_nxt, clean_nxt;
  logic [63:0]   cur_frame_r;
  logic [31:0]   evict_r, evict_nxt;
  logic [31:0]   new_gen, res_gen;
  logic          do_alloc, have_page;
  out_item_t     out_r;

  logic          occ, hit_now, old_now;
  logic [PW+5:0] pg_ext;
  logic [CW+6:0] cached_ext, dirty_ext, clean_ext;

  assign stat.need_scan = in_data.key_valid &&
                          (in_data.op == OP_REQUEST || in_data.op == OP_RENDERED ||
                           in_data.op == OP_INVAL);
  assign stat.scan_last = (scan_cnt_r == PW'(PAGES - 1));
  assign out_data = out_r;

  // input capture and scan addressing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.op;
      kh_r  <= in_data.key_high[KW-1:0];
      kl_r  <= in_data.key_low[KW-1:0];
      kv_r  <= in_data.key_valid;
      fin_r <= in_data.frame_index;
    end
    if (cmd.scan_start) scan_cnt_r <= '0;
    else if (cmd.scan_step) scan_cnt_r <= scan_cnt_r + PW'(1);
    cmp_idx_r <= scan_cnt_r;
    rd_st_r   <= pstat_r[scan_cnt_r];
    rd_pin_r  <= pin_r[scan_cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cmp_vld_r <= 1'b0;
    else        cmp_vld_r <= cmd.scan_step;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.scan_step) rd_kh_r <= key_hi_mem[scan_cnt_r];
    if (cmd.commit && do_alloc) key_hi_mem[pg_r] <= kh_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) rd_kl_r <= key_lo_mem[scan_cnt_r];
    if (cmd.commit && do_alloc) key_lo_mem[pg_r] <= kl_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) rd_lf_r <= lf_mem[scan_cnt_r];
    if (cmd.commit && (do_alloc || code_r == RS_HIT)) lf_mem[pg_r] <= cur_frame_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) gen_rd_r <= gen_mem[pg_nxt];
    if (cmd.commit && do_alloc) gen_mem[pg_r] <= new_gen;
  end

  // scan compare
  assign occ     = (rd_st_r != PS_FREE);
  assign hit_now = cmp_vld_r && occ && !hit_found_r && rd_kh_r == kh_r && rd_kl_r == kl_r;
  assign old_now = cmp_vld_r && occ && !rd_pin_r && (!old_found_r || rd_lf_r < old_best_r);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      hit_found_r <= 1'b0;
      old_found_r <= 1'b0;
    end else begin
      if (hit_now) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= cmp_idx_r;
        hit_st_r    <= rd_st_r;
      end
      if (old_now) begin
        old_found_r <= 1'b1;
        old_idx_r   <= cmp_idx_r;
        old_st_r    <= rd_st_r;
        old_best_r  <= rd_lf_r;
      end
    end
  end

  // page pick
  always_comb begin
    code_nxt   = RS_DONE;
    pg_nxt     = '0;
    sel_st_nxt = PS_FREE;
    unique case (op_r)
      OP_REQUEST: begin
        if (!kv_r) begin
          code_nxt = RS_INVALID;
        end else if (hit_found_r) begin
          code_nxt   = RS_HIT;
          pg_nxt     = hit_idx_r;
          sel_st_nxt = hit_st_r;
        end else if (fresh_r < CW'(PAGES)) begin
          code_nxt = RS_FRESH;
          pg_nxt   = fresh_r[PW-1:0];
        end else if (old_found_r) begin
          code_nxt   = RS_EVICT;
          pg_nxt     = old_idx_r;
          sel_st_nxt = old_st_r;
        end else begin
          code_nxt = RS_NO_PAGE;
        end
      end
      OP_RENDERED, OP_INVAL: begin
        if (kv_r && hit_found_r) begin
          code_nxt   = RS_FOUND;
          pg_nxt     = hit_idx_r;
          sel_st_nxt = hit_st_r;
        end else begin
          code_nxt = RS_NOT_FOUND;
        end
      end
      default: code_nxt = RS_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      code_r   <= code_nxt;
      pg_r     <= pg_nxt;
      sel_st_r <= sel_st_nxt;
    end
  end

  // commit
  assign do_alloc  = (code_r == RS_FRESH) || (code_r == RS_EVICT);
  assign have_page = do_alloc || code_r == RS_HIT || code_r == RS_FOUND;
  assign new_gen   = ((sel_st_r == PS_FREE) ? 32'd0 : gen_rd_r) + 32'd1;

  always_comb begin
    cached_nxt = cached_r;
    dirty_nxt  = dirty_r;
    clean_nxt  = clean_r;
    evict_nxt  = evict_r;
    res_gen    = 32'd0;
    case (code_r)
      RS_HIT: res_gen = gen_rd_r;
      RS_FRESH: begin
        res_gen    = new_gen;
        cached_nxt = cached_r + CW'(1);
        dirty_nxt  = dirty_r + CW'(1);
      end
      RS_EVICT: begin
        res_gen = new_gen;
        if (evict_r != '1) evict_nxt = evict_r + 32'd1;
        if (sel_st_r == PS_CLEAN) begin
          clean_nxt = clean_r - CW'(1);
          dirty_nxt = dirty_r + CW'(1);
        end
      end
      RS_FOUND: begin
        res_gen = gen_rd_r;
        if (op_r == OP_RENDERED && sel_st_r == PS_DIRTY) begin
          dirty_nxt = dirty_r - CW'(1);
          clean_nxt = clean_r + CW'(1);
        end else if (op_r == OP_INVAL && sel_st_r == PS_CLEAN) begin
          dirty_nxt = dirty_r + CW'(1);
          clean_nxt = clean_r - CW'(1);
        end
      end
      RS_DONE: begin
        if (op_r == OP_BEGIN) begin
          evict_nxt = 32'd0;
        end else if (op_r == OP_INVAL_ALL) begin
          dirty_nxt = cached_r;
          clean_nxt = '0;
        end
      end
      default: res_gen = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r     <= '0;
      cached_r    <= '0;
      dirty_r     <= '0;
      clean_r     <= '0;
      evict_r     <= '0;
      cur_frame_r <= '0;
      for (int i = 0; i < PAGES; i++) begin
        pstat_r[i] <= PS_FREE;
        pin_r[i]   <= 1'b0;
      end
    end else if (cmd.commit) begin
      cached_r <= cached_nxt;
      dirty_r  <= dirty_nxt;
      clean_r  <= clean_nxt;
      evict_r  <= evict_nxt;
      if (code_r == RS_FRESH) fresh_r <= fresh_r + CW'(1);
      if (code_r == RS_DONE && op_r == OP_BEGIN) cur_frame_r <= fin_r;
      for (int i = 0; i < PAGES; i++) begin
        if (code_r == RS_DONE && op_r == OP_BEGIN) begin
          pin_r[i] <= 1'b0;
        end else if ((do_alloc || code_r == RS_HIT) && pg_r == PW'(i)) begin
          pin_r[i] <= 1'b1;
        end
        if (code_r == RS_DONE && op_r == OP_INVAL_ALL) begin
          if (pstat_r[i] != PS_FREE) pstat_r[i] <= PS_DIRTY;
        end else if (pg_r == PW'(i)) begin
          if (do_alloc) begin
            pstat_r[i] <= PS_DIRTY;
          end else if (code_r == RS_FOUND) begin
            if (op_r == OP_INVAL) pstat_r[i] <= PS_DIRTY;
            else if (sel_st_r == PS_DIRTY) pstat_r[i] <= PS_CLEAN;
          end
        end
      end
    end
  end

  // result register
  assign pg_ext     = {6'd0, (have_page ? pg_r : PW'(0))};
  assign cached_ext = {7'd0, cached_nxt};
  assign dirty_ext  = {7'd0, dirty_nxt};
  assign clean_ext  = {7'd0, clean_nxt};

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.status             <= code_r;
      out_r.page_index         <= pg_ext[5:0];
      out_r.page_generation    <= res_gen;
      out_r.evictions_in_frame <= evict_nxt;
      out_r.cached_count       <= cached_ext[6:0];
      out_r.dirty_count        <= dirty_ext[6:0];
      out_r.clean_count        <= clean_ext[6:0];
    end
  end

`ifndef SYNTH
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cached_r == dirty_r + clean_r) else $error("page counts disagree");
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= CW'(PAGES)) else $error("fresh pointer past end");
  a_cached_is_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cached_r == fresh_r) else $error("occupancy does not track allocation");
`endif

endmodule

`default_nettype wire

### hw/rtl/frame_lru_page_cache.sv
// ----------------------------------------------------------------------------
// frame_lru_page_cache: fully associative page cache with frame LRU eviction
// Maps two-word keys to physical pages; pins pages per frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one operation per transfer (request,
//   begin frame, mark rendered, invalidate, invalidate all).
//   out_valid/out_stall/out_data carry exactly one result per operation.
//   Operations that look up a key (request, mark rendered and invalidate,
//   each with a valid key) sweep the tag memories one page a cycle, then
//   drain, pick a page and commit; other operations go straight from
//   capture to page pick and commit.
//   One operation is in flight at a time; in_stall is high until its result
//   is registered. The sweep over the single-port tag and frame memories
//   sets how long a lookup takes.
//   A held result (out_stall high) waits in the output register; the next
//   operation is accepted and worked on, and commits once the register frees.
//   Reset (rst_n low, synchronous) frees all pages, clears pins, counters,
//   current frame and eviction count. There is no clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_lru_page_cache import flpc_pkg::*; #(
  parameter int PAGES     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  flpc_cmd_t  cmd;
  flpc_stat_t stat;

  flpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  flpc_dp #(
    .PAGES     (PAGES),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
